// ===== rtl/mqtt_receive_packet_parser_macros.svh =====
// ----------------------------------------------------------------------------
// MQTT receive parser assertion macros
// Concurrent check wrappers shared by the parser RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef MQTT_RECEIVE_PACKET_PARSER_MACROS_SVH
`define MQTT_RECEIVE_PACKET_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MRPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MRPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MRPP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MRPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/mrpp_pkg.sv =====
// ----------------------------------------------------------------------------
// MQTT receive parser package
// Types, codes and helpers shared by the receive parser modules.
// ----------------------------------------------------------------------------
package mrpp_pkg;

   localparam int LENGTH_GROUPS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF   = 4;
   localparam int MAX_RESULTS       = 3;

   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;

   localparam logic [1:0] QOS_AT_MOST_ONCE  = 2'd0;
   localparam logic [1:0] QOS_AT_LEAST_ONCE = 2'd1;

   localparam logic [7:0] CONNACK_ACCEPTED = 8'h00;

   typedef enum logic [3:0] {
      PH_HDR,
      PH_LEN,
      PH_TLEN_HI,
      PH_TLEN_LO,
      PH_TOPIC,
      PH_ID_HI,
      PH_ID_LO,
      PH_PAYLOAD,
      PH_CONNACK,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TOPIC,
      KIND_PAYLOAD,
      KIND_END,
      KIND_PUBACK,
      KIND_CONN_OK,
      KIND_CONN_BAD,
      KIND_MALFORMED
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] packet_id;
      logic [7:0]  return_code;
      logic [1:0]  qos;
   } result_type;

   // all results caused by one received byte
   typedef struct packed {
      logic [1:0]                     count;
      logic                           connected;
      result_type [MAX_RESULTS-1:0]   res;
   } group_type;

   function automatic result_type make_result(kind_type kind, logic [7:0] data,
                                              logic [15:0] id, logic [7:0] rc,
                                              logic [1:0] q);
      result_type r;
      r.kind        = kind;
      r.data        = data;
      r.packet_id   = id;
      r.return_code = rc;
      r.qos         = q;
      return r;
   endfunction

endpackage

// ===== rtl/mrpp_req_if.sv =====
// ----------------------------------------------------------------------------
// MQTT receive parser request channel
// Valid/ready channel carrying one received byte or a session reset.
// ----------------------------------------------------------------------------
interface mrpp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, op, rx_byte, input ready);
   modport sink   (input valid, op, rx_byte, output ready);
endinterface

// ===== rtl/mrpp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// MQTT receive parser result channel
// Valid/ready channel carrying one decoded result.
// ----------------------------------------------------------------------------
interface mrpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data;
   logic [15:0] packet_id;
   logic [7:0]  return_code;
   logic [1:0]  qos;
   logic        connected;
   logic        last;

   modport source (output valid, kind, data, packet_id, return_code, qos, connected,
                   last, input ready);
   modport sink   (input valid, kind, data, packet_id, return_code, qos, connected,
                   last, output ready);
endinterface

// ===== rtl/mqtt_receive_packet_parser.sv =====
// ----------------------------------------------------------------------------
// MQTT receive packet parser
// Deframes an MQTT 3.1.1 broker-to-client byte stream into decoded results.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one transfer per received byte (op = 0) or a session reset
//   (op = 1). A byte is taken in any cycle in which the result queue has room
//   for its group, so bytes stream in at one per cycle.
//   rsp_chan gives decoded results: topic and payload bytes, message end,
//   PUBACK requests, CONNACK verdicts and malformed-packet flags. One byte
//   causes zero to three results; last marks the final one of each byte.
//   A byte's group is registered into the queue when the byte is taken, behind
//   any groups already queued. Bytes go in at one per cycle while each byte
//   gives at most one result and the receiver is ready; the result port sends
//   one result per cycle, so a byte closing a publish (up to three results)
//   takes a transfer per result and the queue of QUEUE_DEPTH groups absorbs it.
//   Reset clears the parser (waiting for a fixed header, disconnected) and
//   empties the queue. A session reset clears the parser only; results already
//   queued still go out. When the receiver stalls, the queue fills and
//   req_chan.ready drops until a group has been sent.
// ----------------------------------------------------------------------------
module mqtt_receive_packet_parser
   import mrpp_pkg::*;
#(
   parameter int LENGTH_GROUPS = LENGTH_GROUPS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mrpp_req_if.sink   req_chan,
   mrpp_rsp_if.source rsp_chan
);

   logic      accept;
   logic      has_space;
   logic      push;
   group_type group;

   // take a byte only when a whole result group fits
   assign req_chan.ready = has_space;
   assign accept         = req_chan.valid && has_space;

   // decode the byte against the running packet state
   mrpp_parser #(
      .LENGTH_GROUPS (LENGTH_GROUPS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (req_chan.op),
      .rx_byte (req_chan.rx_byte),
      .push    (push),
      .group   (group)
   );

   // hold groups and send their results one transfer at a time
   mrpp_group_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (group),
      .has_space  (has_space),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/mrpp_parser.sv =====
// ----------------------------------------------------------------------------
// MQTT receive parser state machine
// Walks the fixed header, remaining length and packet body one byte a cycle while bytes are accepted.
// ----------------------------------------------------------------------------
`include "mqtt_receive_packet_parser_macros.svh"

module mrpp_parser
   import mrpp_pkg::*;
#(
   parameter int LENGTH_GROUPS = LENGTH_GROUPS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  logic      op,
   input  logic [7:0] rx_byte,
   output logic      push,
   output group_type group
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  type_ff, type_in;
   logic [3:0]  flags_ff, flags_in;
   logic [2:0]  groups_ff, groups_in;
   logic [27:0] left_ff, left_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] id_ff, id_in;
   logic [1:0]  cidx_ff, cidx_in;
   logic        conn_ff, conn_in;

   logic [1:0]  qos;
   phase_type   after_topic;
   logic [27:0] len_add, len_sum, left_dec;
   logic [2:0]  groups_inc;
   logic        len_overflow, body_end;
   logic [15:0] tlen_lo_val;
   phase_type   pub_phase;
   logic [15:0] pub_tlen, pub_id;

   assign qos          = flags_ff[2:1];
   assign after_topic  = (qos != QOS_AT_MOST_ONCE) ? PH_ID_HI : PH_PAYLOAD;
   assign groups_inc   = groups_ff + 3'd1;
   assign len_overflow = groups_inc >= 3'(LENGTH_GROUPS);
   assign len_sum      = left_ff + len_add;
   assign left_dec     = left_ff - 28'd1;
   assign body_end     = left_ff == 28'd1;
   assign tlen_lo_val  = {tlen_ff[15:8], rx_byte};

   // place the 7-bit group by its position, least significant first
   always_comb begin
      case (groups_ff[1:0])
         2'd0:    len_add = {21'd0, rx_byte[6:0]};
         2'd1:    len_add = {14'd0, rx_byte[6:0], 7'd0};
         2'd2:    len_add = {7'd0, rx_byte[6:0], 14'd0};
         default: len_add = {rx_byte[6:0], 21'd0};
      endcase
   end

   // publish body step before the end-of-packet check
   always_comb begin
      pub_phase = phase_ff;
      pub_tlen  = tlen_ff;
      pub_id    = id_ff;
      case (phase_ff)
         PH_TLEN_HI: begin
            pub_tlen  = {rx_byte, 8'h00};
            pub_phase = PH_TLEN_LO;
         end
         PH_TLEN_LO: begin
            pub_tlen  = tlen_lo_val;
            pub_phase = (tlen_lo_val != 16'd0) ? PH_TOPIC : after_topic;
         end
         PH_TOPIC: begin
            pub_tlen  = tlen_ff - 16'd1;
            pub_phase = (tlen_ff == 16'd1) ? after_topic : PH_TOPIC;
         end
         PH_ID_HI: begin
            pub_id    = {rx_byte, 8'h00};
            pub_phase = PH_ID_LO;
         end
         PH_ID_LO: begin
            pub_id    = {id_ff[15:8], rx_byte};
            pub_phase = PH_PAYLOAD;
         end
         default: begin
            pub_phase = phase_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      groups_in = groups_ff;
      left_in   = left_ff;
      tlen_in   = tlen_ff;
      id_in     = id_ff;
      cidx_in   = cidx_ff;
      conn_in   = conn_ff;
      if (accept && op) begin
         phase_in  = PH_HDR;
         type_in   = 4'd0;
         flags_in  = 4'd0;
         groups_in = 3'd0;
         left_in   = 28'd0;
         tlen_in   = 16'd0;
         id_in     = 16'd0;
         cidx_in   = 2'd0;
         conn_in   = 1'b0;
      end else if (accept) begin
         case (phase_ff)
            PH_HDR: begin
               type_in   = rx_byte[7:4];
               flags_in  = rx_byte[3:0];
               groups_in = 3'd0;
               left_in   = 28'd0;
               phase_in  = PH_LEN;
            end
            PH_LEN: begin
               left_in   = len_sum;
               groups_in = groups_inc;
               if (rx_byte[7]) begin
                  if (len_overflow) begin
                     phase_in = PH_HDR;
                  end
               end else if (type_ff == TYPE_PUBLISH) begin
                  id_in    = 16'd0;
                  tlen_in  = 16'd0;
                  phase_in = (len_sum == 28'd0) ? PH_HDR : PH_TLEN_HI;
               end else if (len_sum == 28'd0) begin
                  phase_in = PH_HDR;
               end else if (type_ff == TYPE_CONNACK) begin
                  cidx_in  = 2'd0;
                  phase_in = PH_CONNACK;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            PH_CONNACK: begin
               left_in = left_dec;
               if (cidx_ff == 2'd1) begin
                  conn_in = rx_byte == CONNACK_ACCEPTED;
               end
               if (cidx_ff < 2'd2) begin
                  cidx_in = cidx_ff + 2'd1;
               end
               if (body_end) begin
                  phase_in = PH_HDR;
               end
            end
            PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_ID_HI, PH_ID_LO, PH_PAYLOAD: begin
               left_in  = left_dec;
               tlen_in  = pub_tlen;
               id_in    = pub_id;
               phase_in = body_end ? PH_HDR : pub_phase;
            end
            default: begin
               left_in = left_dec;
               if (body_end) begin
                  phase_in = PH_HDR;
               end
            end
         endcase
      end
   end

   // results of this byte
   always_comb begin : build_group
      logic [1:0] slot;
      slot  = 2'd0;
      group = '0;
      if (accept && !op) begin
         case (phase_ff)
            PH_LEN: begin
               if ((rx_byte[7] && len_overflow) ||
                   (!rx_byte[7] && type_ff == TYPE_PUBLISH && len_sum == 28'd0)) begin
                  group.res[slot] = make_result(KIND_MALFORMED, 8'd0, 16'd0, 8'd0, 2'd0);
                  slot = slot + 2'd1;
               end
            end
            PH_CONNACK: begin
               if (cidx_ff == 2'd1) begin
                  group.res[slot] = make_result(
                     (rx_byte == CONNACK_ACCEPTED) ? KIND_CONN_OK : KIND_CONN_BAD,
                     8'd0, 16'd0, rx_byte, 2'd0);
                  slot = slot + 2'd1;
               end
            end
            PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_ID_HI, PH_ID_LO, PH_PAYLOAD: begin
               if (phase_ff == PH_TOPIC) begin
                  group.res[slot] = make_result(KIND_TOPIC, rx_byte, 16'd0, 8'd0, qos);
                  slot = slot + 2'd1;
               end else if (phase_ff == PH_PAYLOAD) begin
                  group.res[slot] = make_result(KIND_PAYLOAD, rx_byte, 16'd0, 8'd0, qos);
                  slot = slot + 2'd1;
               end
               if (body_end) begin
                  if (pub_phase == PH_PAYLOAD) begin
                     group.res[slot] = make_result(KIND_END, 8'd0, pub_id, 8'd0, qos);
                     slot = slot + 2'd1;
                     if (qos == QOS_AT_LEAST_ONCE) begin
                        group.res[slot] = make_result(KIND_PUBACK, 8'd0, pub_id, 8'd0, qos);
                        slot = slot + 2'd1;
                     end
                  end else begin
                     group.res[slot] = make_result(KIND_MALFORMED, 8'd0, 16'd0, 8'd0, 2'd0);
                     slot = slot + 2'd1;
                  end
               end
            end
            default: begin
               slot = 2'd0;
            end
         endcase
      end
      group.count     = slot;
      group.connected = conn_in;
   end

   assign push = group.count != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         type_ff   <= 4'd0;
         flags_ff  <= 4'd0;
         groups_ff <= 3'd0;
         left_ff   <= 28'd0;
         tlen_ff   <= 16'd0;
         id_ff     <= 16'd0;
         cidx_ff   <= 2'd0;
         conn_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         flags_ff  <= flags_in;
         groups_ff <= groups_in;
         left_ff   <= left_in;
         tlen_ff   <= tlen_in;
         id_ff     <= id_in;
         cidx_ff   <= cidx_in;
         conn_ff   <= conn_in;
      end
   end

   `MRPP_ASSERT_NEXT(a_session_reset, clock, reset, accept && op, phase_ff == PH_HDR && !conn_ff, "session reset did not clear parser")
   `MRPP_ASSERT_IMPLY(a_len_groups, clock, reset, phase_ff == PH_LEN, groups_ff < 3'(LENGTH_GROUPS), "length group count out of range")
   `MRPP_ASSERT_IMPLY(a_body_left, clock, reset, phase_ff == PH_CONNACK || phase_ff == PH_SKIP || phase_ff == PH_PAYLOAD, left_ff != 28'd0, "body phase with no bytes left")
   `MRPP_ASSERT_IMPLY(a_topic_left, clock, reset, phase_ff == PH_TOPIC, tlen_ff != 16'd0, "topic phase with empty topic")

endmodule

// ===== rtl/mrpp_group_queue.sv =====
// ----------------------------------------------------------------------------
// MQTT receive parser result queue
// Buffers result groups and sends their results one transfer at a time.
// ----------------------------------------------------------------------------
`include "mqtt_receive_packet_parser_macros.svh"

module mrpp_group_queue
   import mrpp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  group_type     push_group,
   output logic          has_space,
   mrpp_rsp_if.source    rsp_chan
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   group_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [1:0]       slot_ff, slot_in;

   group_type  head;
   result_type cur;
   logic       final_slot, xfer, pop;

   assign head       = entry_ff[rd_ptr_ff];
   assign cur        = head.res[slot_ff];
   assign final_slot = slot_ff == (head.count - 2'd1);
   assign xfer       = rsp_chan.valid && rsp_chan.ready;
   assign pop        = xfer && final_slot;
   assign has_space  = fill_ff < CNT_W'(QUEUE_DEPTH);

   assign rsp_chan.valid       = fill_ff != '0;
   assign rsp_chan.kind        = cur.kind;
   assign rsp_chan.data        = cur.data;
   assign rsp_chan.packet_id   = cur.packet_id;
   assign rsp_chan.return_code = cur.return_code;
   assign rsp_chan.qos         = cur.qos;
   assign rsp_chan.connected   = head.connected;
   assign rsp_chan.last        = final_slot;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      slot_in   = slot_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (xfer) begin
         slot_in = final_slot ? 2'd0 : slot_ff + 2'd1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + CNT_W'(1);
         2'b01:   fill_in = fill_ff - CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         slot_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         slot_ff   <= slot_in;
      end
   end

   `MRPP_ASSERT_IMPLY(a_no_overflow, clock, reset, push, has_space, "group pushed into full queue")
   `MRPP_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(QUEUE_DEPTH), "queue fill beyond depth")
   `MRPP_ASSERT_IMPLY(a_head_nonempty, clock, reset, rsp_chan.valid, head.count != 2'd0 && slot_ff < head.count, "head group slot out of range")
   `MRPP_ASSERT_IMPLY(a_slot_idle, clock, reset, !rsp_chan.valid, slot_ff == 2'd0, "slot index left over with empty queue")

endmodule
